>>> hdl/gerenc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gerenc_pkg: shared types and constants of the gamepad report encoder
// Item kinds, register indexes, report characters and the command word that
// the front end hands to the back end through the command queue.
// ----------------------------------------------------------------------------
package gerenc_pkg;

  // Sizes
  localparam int BUFFER_DEPTH_DEF = 20;
  localparam int CMD_FIFO_DEPTH   = 2;   // power of two
  localparam int THR_W            = 12;
  localparam int SAMPLE_W         = 12;
  localparam int MASK_W           = 6;
  localparam int OP_W             = 2;
  localparam int CHAR_W           = 8;
  localparam int CODE_W           = 4;
  localparam int BTN_W            = 5;   // buffered button bits per port
  localparam int CFG_IDX_W        = 2;
  localparam int S_TDATA_W        = 32;  // 30 payload bits, zero padded
  localparam int M_TDATA_W        = 8;

  // Register reset values
  localparam logic [THR_W-1:0] HIGH_THR_RST = 12'd2400;
  localparam logic [THR_W-1:0] LOW_THR_RST  = 12'd1700;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 2'd1;

  // Item kinds
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_PORT_A = 2'd1;
  localparam logic [OP_W-1:0] OP_PORT_B = 2'd2;

  // Report characters
  localparam logic [CHAR_W-1:0] CH_RIGHT  = 8'h52; // R
  localparam logic [CHAR_W-1:0] CH_LEFT   = 8'h4C; // L
  localparam logic [CHAR_W-1:0] CH_UP     = 8'h55; // U
  localparam logic [CHAR_W-1:0] CH_DOWN   = 8'h4E; // N
  localparam logic [CHAR_W-1:0] CH_SELECT = 8'h23; // #
  localparam logic [CHAR_W-1:0] CH_NONE   = 8'h00;

  // Port B symbols follow the five port A symbols
  localparam logic [CODE_W-1:0] PORT_B_BASE = 4'd5;

  // Command word from front end to back end
  typedef struct packed {
    logic              is_tick;
    logic              x_emit;
    logic [CHAR_W-1:0] x_char;
    logic              y_emit;
    logic [CHAR_W-1:0] y_char;
    logic [BTN_W-1:0]  btn_mask;
    logic              is_port_b;
    logic              sel;
  } cmd_t;

  // Symbol code to report character
  function automatic logic [CHAR_W-1:0] code_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      4'd0:    ch = 8'h3C; // <
      4'd1:    ch = 8'h3E; // >
      4'd2:    ch = 8'h5E; // ^
      4'd3:    ch = 8'h76; // v
      4'd4:    ch = 8'h2A; // *
      4'd5:    ch = 8'h41; // A
      4'd6:    ch = 8'h42; // B
      4'd7:    ch = 8'h43; // C
      4'd8:    ch = 8'h44; // D
      4'd9:    ch = 8'h45; // E
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

>>> hdl/gerenc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gerenc_front: input classifier
// Holds the axis thresholds, decodes each input transfer into a command word
// and pushes it into the command queue. Unused item kinds are dropped.
// ----------------------------------------------------------------------------
module gerenc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gerenc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gerenc_pkg::THR_W-1:0]        cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [gerenc_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic [gerenc_pkg::OP_W-1:0]         s_tuser,
  input  logic                                q_full,
  output logic                                q_push,
  output gerenc_pkg::cmd_t                    q_cmd
);
  import gerenc_pkg::*;

  logic [THR_W-1:0]    high_thr;
  logic [THR_W-1:0]    low_thr;
  logic [MASK_W-1:0]   edge_mask;
  logic [SAMPLE_W-1:0] x_sample;
  logic [SAMPLE_W-1:0] y_sample;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_thr <= HIGH_THR_RST;
      low_thr  <= LOW_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_THR: high_thr <= cfg_wdata;
        REG_LOW_THR:  low_thr  <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  assign edge_mask = s_tdata[MASK_W-1:0];
  assign x_sample  = s_tdata[MASK_W +: SAMPLE_W];
  assign y_sample  = s_tdata[MASK_W+SAMPLE_W +: SAMPLE_W];

  // Classify: axis tests here, buffer work in the back end
  always_comb begin
    q_cmd           = '0;
    q_cmd.is_tick   = (s_tuser == OP_TICK);
    q_cmd.is_port_b = (s_tuser == OP_PORT_B);
    q_cmd.btn_mask  = edge_mask[BTN_W-1:0];
    q_cmd.sel       = (s_tuser == OP_PORT_B) && edge_mask[BTN_W];
    if (x_sample > high_thr) begin
      q_cmd.x_emit = 1'b1;
      q_cmd.x_char = CH_RIGHT;
    end else if (x_sample < low_thr) begin
      q_cmd.x_emit = 1'b1;
      q_cmd.x_char = CH_LEFT;
    end
    if (y_sample > high_thr) begin
      q_cmd.y_emit = 1'b1;
      q_cmd.y_char = CH_UP;
    end else if (y_sample < low_thr) begin
      q_cmd.y_emit = 1'b1;
      q_cmd.y_char = CH_DOWN;
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full &&
                    (s_tuser == OP_TICK || s_tuser == OP_PORT_A || s_tuser == OP_PORT_B);

endmodule

>>> hdl/gerenc_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gerenc_cmd_fifo: command queue
// Short register queue of command words between front end and back end.
// ----------------------------------------------------------------------------
module gerenc_cmd_fifo #(
  parameter int DEPTH = gerenc_pkg::CMD_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gerenc_pkg::cmd_t  push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output gerenc_pkg::cmd_t  pop_cmd
);
  import gerenc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [LW-1:0] level;

  assign full    = (level == LW'(DEPTH));
  assign valid   = (level != '0);
  assign pop_cmd = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_cmd;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push && !full) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop && valid)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      case ({push && !full, pop && valid})
        2'b10:   level <= level + LW'(1);
        2'b01:   level <= level - LW'(1);
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/gerenc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gerenc_back: command executor
// Stores button symbols in the symbol memory one per cycle, sends '#' for a select
// press, and on a tick sends the axis characters and then drains the memory into
// the output register, one character per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module gerenc_back #(
  parameter int BUFFER_DEPTH = gerenc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  gerenc_pkg::cmd_t                  q_cmd,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gerenc_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                              m_tlast
);
  import gerenc_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_TICK, S_DRAIN, S_PUSH, S_SEL} state_t;

  state_t            state;
  logic              x_pend;
  logic [CHAR_W-1:0] x_char;
  logic              y_pend;
  logic [CHAR_W-1:0] y_char;
  logic [BTN_W-1:0]  btn_mask;
  logic              is_port_b;
  logic              sel;
  logic [CW-1:0]     count;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     idx_next;

  logic [CODE_W-1:0] sym_mem [BUFFER_DEPTH];
  logic [CODE_W-1:0] rd_data;
  logic [CODE_W-1:0] wr_code;
  logic              mem_we;

  logic              slot_free;
  logic              out_load;
  logic              last_now;
  logic [2:0]        bit_sel;
  logic [BTN_W-1:0]  mask_clr;

  assign slot_free = !m_tvalid || m_tready;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign last_now  = (CW'(idx) + CW'(1) == count);

  // Output register takes a new character this cycle
  assign out_load  = slot_free && ((state == S_TICK && (x_pend || y_pend)) ||
                                   state == S_DRAIN || state == S_SEL);

  // Lowest pending button bit
  always_comb begin
    bit_sel = '0;
    for (int i = BTN_W - 1; i >= 0; i--) begin
      if (btn_mask[i]) bit_sel = 3'(i);
    end
    mask_clr = btn_mask & ~(BTN_W'(1) << bit_sel);
  end

  assign wr_code = is_port_b ? PORT_B_BASE + CODE_W'(bit_sel) : CODE_W'(bit_sel);
  assign mem_we  = (state == S_PUSH) && (count < CW'(BUFFER_DEPTH));

  // Drain index; the read runs one entry ahead of the output register
  always_comb begin
    idx_next = idx;
    if (state == S_DRAIN && slot_free) idx_next = last_now ? '0 : idx + AW'(1);
  end

  // Symbol memory
  always_ff @(posedge clk) begin
    if (mem_we) sym_mem[count[AW-1:0]] <= wr_code;
    rd_data <= sym_mem[idx_next];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      idx <= idx_next;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            x_pend    <= q_cmd.x_emit;
            x_char    <= q_cmd.x_char;
            y_pend    <= q_cmd.y_emit;
            y_char    <= q_cmd.y_char;
            btn_mask  <= q_cmd.btn_mask;
            is_port_b <= q_cmd.is_port_b;
            sel       <= q_cmd.sel;
            if (q_cmd.is_tick)             state <= S_TICK;
            else if (q_cmd.btn_mask != '0) state <= S_PUSH;
            else if (q_cmd.sel)            state <= S_SEL;
          end
        end
        S_TICK: begin
          if (x_pend) begin
            if (slot_free) begin
              m_tdata  <= x_char;
              m_tlast  <= !y_pend && (count == '0);
              x_pend   <= 1'b0;
              if (!y_pend) state <= (count == '0) ? S_IDLE : S_DRAIN;
            end
          end else if (y_pend) begin
            if (slot_free) begin
              m_tdata  <= y_char;
              m_tlast  <= (count == '0);
              y_pend   <= 1'b0;
              state    <= (count == '0) ? S_IDLE : S_DRAIN;
            end
          end else begin
            state <= (count == '0) ? S_IDLE : S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (slot_free) begin
            m_tdata  <= code_char(rd_data);
            m_tlast  <= last_now;
            if (last_now) begin
              count <= '0;
              state <= S_IDLE;
            end
          end
        end
        S_PUSH: begin
          // full buffer: press dropped
          if (count < CW'(BUFFER_DEPTH)) count <= count + CW'(1);
          btn_mask <= mask_clr;
          if (mask_clr == '0) state <= sel ? S_SEL : S_IDLE;
        end
        S_SEL: begin
          if (slot_free) begin
            m_tdata  <= CH_SELECT;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(BUFFER_DEPTH))
    else $error("symbol count above buffer depth");

  a_drain_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> CW'(idx) < count)
    else $error("drain index beyond stored symbols");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN && slot_free && last_now) |=> (count == '0 && idx == '0))
    else $error("buffer not emptied after final symbol");

  a_push_has_work: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSH |-> btn_mask != '0)
    else $error("store step with no pending button");

endmodule

>>> hdl/gamepad_event_report_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_event_report_encoder_unit: gamepad event report encoder
// Button edges fill a symbol buffer; a tick sends axis characters and the
// buffered symbols as a character stream, the last one marked by tlast.
// ----------------------------------------------------------------------------
// A tick's first character passes through the command queue, the executor's
// state register and the output register; '#' for select follows the storing
// of the set button bits. The executor takes one item at a time: a tick sends
// its characters in turn, and a button item stores one symbol per set bit.
// Reset: thresholds return to 2400 and 1700, buffer count and queue clear;
// symbol memory contents are not cleared (count gates every read).
module gamepad_event_report_encoder_unit #(
  parameter int BUFFER_DEPTH = gerenc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gerenc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gerenc_pkg::THR_W-1:0]        cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // edge_mask[5:0], x_sample[17:6], y_sample[29:18], zero[31:30]
  input  logic [gerenc_pkg::S_TDATA_W-1:0]    s_tdata,
  // op[1:0]
  input  logic [gerenc_pkg::OP_W-1:0]         s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // report_byte[7:0]
  output logic [gerenc_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast
);
  import gerenc_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_out;

  gerenc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  gerenc_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_out)
  );

  gerenc_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
